FILE: hdl/psq_pkg.sv
package psq_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 4;
  localparam int POS_W    = 8;
  localparam int STAT_W   = 3;
  localparam int CNT_W    = 5;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int FILL_W   = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (FILL_W > POS_W) ? FILL_W : POS_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_INS_FRONT = 4'd0,
    KIND_INS_BACK  = 4'd1,
    KIND_INS_AT    = 4'd2,
    KIND_DEL_FRONT = 4'd3,
    KIND_DEL_BACK  = 4'd4,
    KIND_DEL_AT    = 4'd5,
    KIND_REVERSE   = 4'd6,
    KIND_CLEAR     = 4'd7,
    KIND_READ      = 4'd8
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_NEG   = 3'd2,
    ST_RANGE = 3'd3,
    ST_FULL  = 3'd4
  } status_t;

  // What one cell loads at the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_LOAD = 2'd1,
    CELL_PREV = 2'd2,
    CELL_NEXT = 2'd3
  } cell_op_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [DATA_W-1:0] value;
    logic signed [POS_W-1:0]  position;
  } cmd_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] element;
    logic [CNT_W-1:0]         count;
    logic                     last;
  } rsp_t;

endpackage

FILE: hdl/positional_sequence_store.sv
// channel | valid     | stall     | payload         | beat
// --------+-----------+-----------+-----------------+--------------------------------
// command | cmd_valid | cmd_stall | cmd (cmd_t)     | one operation on the sequence
// result  | rsp_valid | rsp_stall | rsp (rsp_t)     | one status or one read element
//
// Edits, clear and errors: one beat in the cycle after accept; all cells shift at once.
// Reverse: status beat goes out at once, then cmd_stall holds while the tail moves to each slot in turn.
// Read out: cmd_stall holds after accept until the last element beat, one element beat per cycle while
// rsp is not stalled, rotating the row so the front cell always carries the next element.
// A stalled result beat holds in rsp and also raises cmd_stall; read out waits with it.
// Reset is synchronous and empties the store at once; cell contents are left as they are.
module positional_sequence_store (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  psq_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output psq_pkg::rsp_t rsp
);
  import psq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_REV  = 3'b010,
    S_READ = 3'b100
  } state_t;

  state_t              state, state_next;
  logic [FILL_W-1:0]   fill, fill_next;
  logic [IDX_W-1:0]    step, step_next;
  logic [IDX_W-1:0]    tail_idx;

  logic [DATA_W-1:0]   cells    [CAPACITY];
  logic [DATA_W-1:0]   prev_val [CAPACITY];
  logic [DATA_W-1:0]   next_val [CAPACITY];
  cell_op_t            cell_op  [CAPACITY];
  logic [DATA_W-1:0]   load_val;

  logic                cmd_acc;
  logic                out_free;
  logic                rsp_load;
  rsp_t                rsp_next;
  status_t             status;

  logic                neg, full, empty;
  logic [CMP_W-1:0]    pos_w, fill_w, at;
  logic                do_ins, do_del;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign cmd_stall = !((state == S_IDLE) && out_free);
  assign cmd_acc   = cmd_valid && !cmd_stall;

  assign neg      = cmd.position[POS_W-1];
  assign pos_w    = CMP_W'($unsigned(cmd.position));
  assign fill_w   = CMP_W'(fill);
  assign full     = (fill == FILL_W'(CAPACITY));
  assign empty    = (fill == '0);
  assign tail_idx = IDX_W'(fill - FILL_W'(1));

  // Neighbor links; the ends of the row see zero.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      prev_val[i] = (i == 0)            ? '0 : cells[(i == 0) ? 0 : i - 1];
      next_val[i] = (i == CAPACITY - 1) ? '0 : cells[(i == CAPACITY - 1) ? i : i + 1];
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_op[i] = CELL_HOLD;
    end
    load_val   = cmd.value;
    fill_next  = fill;
    state_next = state;
    step_next  = step;
    rsp_load   = 1'b0;
    status     = ST_OK;
    at         = '0;
    do_ins     = 1'b0;
    do_del     = 1'b0;
    rsp_next   = '0;

    unique case (state)
      S_IDLE: begin
        if (cmd_acc) begin
          rsp_load = 1'b1;
          unique case (cmd.kind)
            KIND_INS_FRONT: begin
              if (full) status = ST_FULL;
              else      do_ins = 1'b1;
            end
            KIND_INS_BACK: begin
              at = fill_w;
              if (full) status = ST_FULL;
              else      do_ins = 1'b1;
            end
            KIND_INS_AT: begin
              at = pos_w;
              priority if (neg)            status = ST_NEG;
              else if (pos_w > fill_w)     status = ST_RANGE;
              else if (full)               status = ST_FULL;
              else                         do_ins = 1'b1;
            end
            KIND_DEL_FRONT: begin
              if (empty) status = ST_EMPTY;
              else       do_del = 1'b1;
            end
            KIND_DEL_BACK: begin
              // Dropping the tail only needs the fill to shrink.
              if (empty) status = ST_EMPTY;
              else       fill_next = fill - FILL_W'(1);
            end
            KIND_DEL_AT: begin
              at = pos_w;
              priority if (neg)                status = ST_NEG;
              else if (empty && pos_w == '0)   status = ST_EMPTY;
              else if (pos_w >= fill_w)        status = ST_RANGE;
              else                             do_del = 1'b1;
            end
            KIND_REVERSE: begin
              if (fill >= FILL_W'(2)) begin
                state_next = S_REV;
                step_next  = '0;
              end
            end
            KIND_CLEAR: fill_next = '0;
            KIND_READ: begin
              if (empty) begin
                status = ST_EMPTY;
              end else begin
                rsp_load   = 1'b0;
                state_next = S_READ;
                step_next  = '0;
              end
            end
            default: ;
          endcase

          if (do_ins) begin
            fill_next = fill + FILL_W'(1);
            for (int i = 0; i < CAPACITY; i++) begin
              if (CMP_W'(i) < at)       cell_op[i] = CELL_HOLD;
              else if (CMP_W'(i) == at) cell_op[i] = CELL_LOAD;
              else                      cell_op[i] = CELL_PREV;
            end
          end
          if (do_del) begin
            fill_next = fill - FILL_W'(1);
            for (int i = 0; i < CAPACITY; i++) begin
              if (CMP_W'(i) >= at) cell_op[i] = CELL_NEXT;
            end
          end

          rsp_next.status  = status;
          rsp_next.element = '0;
          rsp_next.count   = CNT_W'(fill_next);
          rsp_next.last    = 1'b1;
        end
      end

      S_REV: begin
        // Move the tail element into slot step; everything from step on
        // slides back by one.
        load_val = cells[tail_idx];
        for (int i = 0; i < CAPACITY; i++) begin
          if (IDX_W'(i) < step)       cell_op[i] = CELL_HOLD;
          else if (IDX_W'(i) == step) cell_op[i] = CELL_LOAD;
          else                        cell_op[i] = CELL_PREV;
        end
        if (step == IDX_W'(fill - FILL_W'(2))) state_next = S_IDLE;
        else                                  step_next  = step + IDX_W'(1);
      end

      S_READ: begin
        // Emit the front cell, then rotate the live part of the row.
        load_val = cells[0];
        if (out_free) begin
          for (int i = 0; i < CAPACITY; i++) begin
            cell_op[i] = (IDX_W'(i) == tail_idx) ? CELL_LOAD : CELL_NEXT;
          end
          rsp_load         = 1'b1;
          rsp_next.status  = ST_OK;
          rsp_next.element = cells[0];
          rsp_next.count   = CNT_W'(fill);
          rsp_next.last    = (step == tail_idx);
          if (step == tail_idx) state_next = S_IDLE;
          else                  step_next  = step + IDX_W'(1);
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    psq_cell u_cell (
      .clk      (clk),
      .op       (cell_op[g]),
      .load_val (load_val),
      .prev_val (prev_val[g]),
      .next_val (next_val[g]),
      .q        (cells[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      step      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      step  <= step_next;
      if (rsp_load)        rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  // Result payload; hold while stalled.
  always_ff @(posedge clk) begin
    if (rsp_load) rsp <= rsp_next;
  end

endmodule

FILE: hdl/psq_cell.sv
module psq_cell (
  input  logic                     clk,
  input  psq_pkg::cell_op_t        op,
  input  logic [psq_pkg::DATA_W-1:0] load_val,
  input  logic [psq_pkg::DATA_W-1:0] prev_val,
  input  logic [psq_pkg::DATA_W-1:0] next_val,
  output logic [psq_pkg::DATA_W-1:0] q
);
  import psq_pkg::*;

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_HOLD: q <= q;
      CELL_LOAD: q <= load_val;
      CELL_PREV: q <= prev_val;
      CELL_NEXT: q <= next_val;
    endcase
  end

endmodule

FILE: hdl/psq_chk.sv
module psq_chk (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_stall,
  input psq_pkg::cmd_t cmd,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input psq_pkg::rsp_t rsp
);
  import psq_pkg::*;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  logic cmd_seen;
  assign cmd_seen = cmd_valid && (cmd.kind == cmd.kind);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result beat changed while stalled");

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.last && rsp.element == '0)
    else $error("error status not a single zero beat");

  a_empty_cnt: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_EMPTY |-> rsp.count == '0)
    else $error("empty status with nonzero count");

  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |-> rsp.count == FULL_CNT)
    else $error("full status below capacity");

  a_no_accept_blocked: assert property (@(posedge clk) disable iff (rst)
    cmd_seen && !cmd_stall |-> !(rsp_valid && rsp_stall))
    else $error("command taken while a result beat is stalled");

endmodule

bind positional_sequence_store psq_chk u_psq_chk (.*);

FILE: sim/positional_sequence_store_tb.sv
`timescale 1ns / 100ps

module positional_sequence_store_tb;
  import psq_pkg::*;

  localparam int RANDOM_OPS  = 150;
  localparam int CYCLE_LIMIT = 600000;
  // Reverse keeps the command side stalled while it moves the elements.
  localparam int SETTLE      = 2 * CAPACITY + 8;

  typedef struct {
    logic drain;   // hold the sender until every due result has arrived
    cmd_t cmd;
  } pending_t;

  logic  clk;
  logic  rst       = 1'b1;
  logic  cmd_valid = 1'b0;
  logic  cmd_stall;
  cmd_t  cmd       = '0;
  logic  rsp_valid;
  logic  rsp_stall = 1'b0;
  rsp_t  rsp;

  positional_sequence_store u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Shadow copy of the sequence, front at index 0.
  logic signed [DATA_W-1:0] seq_cells [CAPACITY];
  int seq_len = 0;

  pending_t pending [$];
  rsp_t     results_due [$];

  int gen_len         = 0;  // length the stimulus generator assumes
  int cycle_count     = 0;
  int cmds_sent       = 0;
  int beats_checked   = 0;
  int bad_status_seen = 0;
  int peak_len        = 0;
  int fails           = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Shift the tail back by one and drop the value into the opened slot.
  function automatic status_t open_slot(input int at, input logic signed [DATA_W-1:0] v);
    int i;
    if (seq_len >= CAPACITY) return ST_FULL;
    for (i = seq_len; i > at; i--) seq_cells[i] = seq_cells[i-1];
    seq_cells[at] = v;
    seq_len++;
    return ST_OK;
  endfunction

  // Pull the tail forward over the removed slot.
  function automatic void close_slot(input int at);
    int i;
    for (i = at; i + 1 < seq_len; i++) seq_cells[i] = seq_cells[i+1];
    seq_len--;
  endfunction

  // Apply one accepted command to the shadow and queue the beats it must produce.
  task automatic compute_results(input cmd_t c);
    status_t st;
    rsp_t    r;
    int      ip;
    int      i;
    logic signed [DATA_W-1:0] t;
    st = ST_OK;
    ip = int'(c.position);
    case (c.kind)
      KIND_INS_FRONT: st = open_slot(0, c.value);
      KIND_INS_BACK:  st = open_slot(seq_len, c.value);
      KIND_INS_AT: begin
        if (ip < 0) st = ST_NEG;
        else if (ip > seq_len) st = ST_RANGE;
        else st = open_slot(ip, c.value);
      end
      KIND_DEL_FRONT: begin
        if (seq_len == 0) st = ST_EMPTY;
        else close_slot(0);
      end
      KIND_DEL_BACK: begin
        if (seq_len == 0) st = ST_EMPTY;
        else seq_len--;
      end
      KIND_DEL_AT: begin
        if (ip < 0) st = ST_NEG;
        else if (seq_len == 0 && ip == 0) st = ST_EMPTY;
        else if (ip >= seq_len) st = ST_RANGE;
        else close_slot(ip);
      end
      KIND_REVERSE: begin
        for (i = 0; i < seq_len / 2; i++) begin
          t = seq_cells[i];
          seq_cells[i] = seq_cells[seq_len-1-i];
          seq_cells[seq_len-1-i] = t;
        end
      end
      KIND_CLEAR: seq_len = 0;
      default: ;  // unused kinds leave everything alone
    endcase
    if (seq_len > peak_len) peak_len = seq_len;
    r.count = CNT_W'(seq_len);
    if (c.kind == KIND_READ && seq_len > 0) begin
      for (i = 0; i < seq_len; i++) begin
        r.status  = ST_OK;
        r.element = seq_cells[i];
        r.last    = (i == seq_len - 1);
        results_due.push_back(r);
      end
    end else begin
      r.status  = (c.kind == KIND_READ) ? ST_EMPTY : st;
      r.element = '0;
      r.last    = 1'b1;
      if (r.status != ST_OK) bad_status_seen++;
      results_due.push_back(r);
    end
  endtask

  // Queue one command and track the length it leaves behind, so that
  // positions can be aimed at the valid range.
  task automatic queue_op(input kind_t k, input logic signed [DATA_W-1:0] v,
                          input logic signed [POS_W-1:0] p);
    pending_t e;
    int       ip;
    e.drain        = 1'b0;
    e.cmd.kind     = k;
    e.cmd.value    = v;
    e.cmd.position = p;
    pending.push_back(e);
    ip = int'(p);
    case (k)
      KIND_INS_FRONT, KIND_INS_BACK: if (gen_len < CAPACITY) gen_len++;
      KIND_INS_AT: if (ip >= 0 && ip <= gen_len && gen_len < CAPACITY) gen_len++;
      KIND_DEL_FRONT, KIND_DEL_BACK: if (gen_len > 0) gen_len--;
      KIND_DEL_AT: if (ip >= 0 && ip < gen_len) gen_len--;
      KIND_CLEAR: gen_len = 0;
      default: ;
    endcase
  endtask

  task automatic queue_drain();
    pending_t e;
    e.drain = 1'b1;
    e.cmd   = '0;
    pending.push_back(e);
  endtask

  // Command driver: hold the beat while stalled, otherwise advance through
  // the pending queue after a random gap. Each signal gets one assignment.
  always @(posedge clk) begin : drive_cmd
    int       gap_left;
    int       calm_left;
    logic     next_valid;
    cmd_t     next_cmd;
    pending_t e;
    if (rst) begin
      gap_left  = 0;
      calm_left = 0;
      cmd_valid <= 1'b0;
      cmd       <= '0;
    end else begin
      next_valid = cmd_valid;
      next_cmd   = cmd;
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 149) == 0) calm_left = $urandom_range(30, 80);
      if (cmd_valid && !cmd_stall) begin
        compute_results(cmd);
        cmds_sent++;
        next_valid = 1'b0;
        gap_left   = (calm_left > 0) ? 0 : gap_len();
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0) begin
          if (pending[0].drain) begin
            if (results_due.size() == 0) pending.delete(0);
          end else begin
            e = pending.pop_front();
            next_valid = 1'b1;
            next_cmd   = e.cmd;
          end
        end
      end
      cmd_valid <= next_valid;
      cmd       <= next_cmd;
    end
  end

  // Result side: stall in runs, with rsp_stall dropping between any two runs.
  always @(posedge clk) begin : drive_stall
    int stall_left;
    int calm_left;
    if (rst) begin
      stall_left = 0;
      calm_left  = 0;
      rsp_stall <= 1'b0;
    end else begin
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 149) == 0) calm_left = $urandom_range(30, 80);
      if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
        stall_left = (calm_left > 0) ? 0 : gap_len();
      end
    end
  end

  // Monitor: compare each accepted result beat with the oldest one due.
  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      beats_checked++;
      if (results_due.size() == 0) begin
        $error("result beat with nothing due: status %0d element %0d count %0d last %0d",
               rsp.status, rsp.element, rsp.count, rsp.last);
        fails++;
      end else begin
        want = results_due.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          fails++;
        end
        if (rsp.element !== want.element) begin
          $error("element: expected %0d, got %0d", want.element, rsp.element);
          fails++;
        end
        if (rsp.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, rsp.count);
          fails++;
        end
        if (rsp.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, rsp.last);
          fails++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still due", cycle_count,
             results_due.size());
    $display("positional_sequence_store test failed");
    $finish;
  end

  initial begin : stimulus
    int n;
    int r;
    int top;
    int ins_w;
    int del_w;
    kind_t k;
    logic signed [POS_W-1:0] p;

    // Empty store: every delete, read and out-of-range insert must report, nothing may change.
    queue_op(KIND_READ, 32'sd0, 8'sd0);
    queue_op(KIND_DEL_FRONT, 32'sd0, 8'sd0);
    queue_op(KIND_DEL_BACK, 32'sd0, 8'sd0);
    queue_op(KIND_DEL_AT, 32'sd0, 8'sd0);
    queue_op(KIND_DEL_AT, 32'sd0, 8'sd1);
    queue_op(KIND_DEL_AT, 32'sd0, -8'sd1);
    queue_op(KIND_INS_AT, 32'sh7FFFFFFF, -8'sd128);
    queue_op(KIND_INS_AT, 32'sh7FFFFFFF, 8'sd1);
    // Value extremes, insert at the end position, reverse of an even length.
    queue_op(KIND_INS_AT, 32'sh80000000, 8'sd0);
    queue_op(KIND_INS_FRONT, 32'sh7FFFFFFF, 8'sd0);
    queue_op(KIND_INS_BACK, 32'sd0, 8'sd0);
    queue_op(KIND_INS_AT, 32'sd5, 8'sd127);
    queue_op(KIND_INS_AT, 32'hFFFFFFFF, 8'sd3);
    queue_op(KIND_REVERSE, 32'sd0, 8'sd0);
    queue_op(KIND_READ, 32'sd0, 8'sd0);
    queue_op(KIND_DEL_AT, 32'sd0, 8'sd1);
    queue_op(KIND_DEL_FRONT, 32'sd0, 8'sd0);
    queue_op(KIND_DEL_BACK, 32'sd0, 8'sd0);
    // Unused kinds are ignored; reverse of one and of none is a no-op.
    queue_op(kind_t'(4'd15), 32'hFFFFFFFF, 8'sd127);
    queue_op(kind_t'(4'd9), 32'sd1, -8'sd1);
    queue_op(KIND_REVERSE, 32'sd0, 8'sd0);
    queue_op(KIND_READ, 32'sd0, 8'sd0);
    queue_op(KIND_CLEAR, 32'sd0, 8'sd0);
    queue_op(KIND_REVERSE, 32'sd0, 8'sd0);
    // Fill to capacity, then hit the full store from every insert kind.
    for (n = 0; n < CAPACITY; n++) queue_op(KIND_INS_BACK, $urandom, 8'($urandom));
    queue_op(KIND_INS_FRONT, 32'sd1, 8'sd0);
    queue_op(KIND_INS_BACK, 32'sd1, 8'sd0);
    queue_op(KIND_INS_AT, 32'sd1, 8'(CAPACITY));
    queue_op(KIND_INS_AT, 32'sd1, 8'(CAPACITY + 1));
    queue_op(KIND_DEL_AT, 32'sd0, 8'(CAPACITY));
    queue_op(KIND_REVERSE, 32'sd0, 8'sd0);
    queue_op(KIND_READ, 32'sd0, 8'sd0);
    queue_op(KIND_DEL_AT, 32'sd0, 8'(CAPACITY - 1));
    queue_drain();

    // Random part: alternate growing, shrinking and mixed stretches so the
    // length sweeps between empty and full; positions mostly land in range.
    for (n = 0; n < RANDOM_OPS; n++) begin
      if (n == RANDOM_OPS / 2) queue_drain();
      case ((n / 40) % 3)
        0:       begin ins_w = 65; del_w = 15; end
        1:       begin ins_w = 20; del_w = 60; end
        default: begin ins_w = 40; del_w = 40; end
      endcase
      r = $urandom_range(0, 99);
      if (r < ins_w) k = kind_t'($urandom_range(0, 2));
      else if (r < ins_w + del_w) k = kind_t'($urandom_range(3, 5));
      else if (r < ins_w + del_w + 7) k = KIND_REVERSE;
      else if (r < ins_w + del_w + 17) k = KIND_READ;
      else if (r < ins_w + del_w + 19) k = KIND_CLEAR;
      else k = kind_t'($urandom_range(9, 15));
      if (k == KIND_INS_AT || k == KIND_DEL_AT) begin
        top = (k == KIND_INS_AT) ? gen_len : gen_len - 1;
        r = $urandom_range(0, 99);
        if (r < 6) p = 8'($urandom_range(128, 255));
        else if (r < 14 || top < 0) p = 8'($urandom_range(top + 1, 127));
        else p = 8'($urandom_range(0, top));
      end else begin
        p = 8'($urandom);
      end
      queue_op(k, $urandom, p);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() > 0 || cmd_valid) @(posedge clk);
    while (results_due.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (results_due.size() != 0) begin
      $error("%0d result beats never arrived", results_due.size());
      fails++;
    end
    $display("%0d commands sent, %0d result beats checked, peak length %0d of %0d",
             cmds_sent, beats_checked, peak_len, CAPACITY);
    $display("%0d edits or reads reported empty, negative, out of range or full",
             bad_status_seen);
    if (fails == 0) begin
      $display("positional_sequence_store test passed");
    end else begin
      $display("positional_sequence_store test failed");
    end
    $finish;
  end

endmodule
